[rtl/fpr_pkg.sv]
// Shared constants, types and the CRC8 step for the framed packet receiver.
// Used by every module of the block except fpr_ram; depends on nothing else.
`default_nettype none

package fpr_pkg;

    // Frame geometry
    localparam int MAX_FRAME   = 32;
    localparam int STORE_DEPTH = MAX_FRAME - 4;
    localparam int RAM_DEPTH   = 2 * STORE_DEPTH;
    localparam int RAM_AW      = $clog2(RAM_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    // Line bytes and polynomial
    localparam logic [7:0] START_BYTE = 8'haa;
    localparam logic [7:0] ACK_BYTE   = 8'h55;
    localparam logic [7:0] CRC_POLY   = 8'h8c;
    localparam logic [7:0] MIN_LEN    = 8'd4;
    localparam logic [7:0] MAX_LEN    = 8'(MAX_FRAME);

    // Check modes
    localparam logic [1:0] CHECK_EITHER   = 2'd0;
    localparam logic [1:0] CHECK_SUM_ONLY = 2'd1;
    localparam logic [1:0] CHECK_CRC_ONLY = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_ACK    = 2'd1;
    localparam logic [1:0] KIND_REJECT = 2'd2;

    // Reject causes
    localparam logic [1:0] CAUSE_NONE = 2'd0;
    localparam logic [1:0] CAUSE_FULL = 2'd1;
    localparam logic [1:0] CAUSE_DUP  = 2'd2;
    localparam logic [1:0] CAUSE_BAD  = 2'd3;

    // Command passed from the parser to the delivery side
    typedef struct packed {
        logic       deliver;
        logic [1:0] kind;
        logic [1:0] cause;
        logic [7:0] len;
        logic       bank;
    } cmd_t;

    // One byte of Dallas CRC8, reflected, eight bit steps
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[rtl/fpr_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; holds the data bytes of received frames.
`default_nettype none

module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 56
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port, and a read port whose data holds until the next read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/fpr_front.sv]
// Frame parser: accepts serial words, checks toggle, length and checksum,
// stores data bytes in the RAM and queues commands. Depends on fpr_pkg.
`default_nettype none

module fpr_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic [7:0]                rx_byte,
    input  wire logic                      room_ok,
    input  wire logic [1:0]                check_mode,
    output logic                           push,
    output fpr_pkg::cmd_t                  push_cmd,
    input  wire logic                      queue_full,
    input  wire logic                      deliver_done,
    output logic                           ram_we,
    output logic      [fpr_pkg::RAM_AW-1:0] ram_waddr,
    output logic      [7:0]                ram_wdata
);
    import fpr_pkg::*;

    localparam logic [2:0] PH_HUNT   = 3'd0;
    localparam logic [2:0] PH_TOGGLE = 3'd1;
    localparam logic [2:0] PH_CHK    = 3'd2;
    localparam logic [2:0] PH_LEN    = 3'd3;
    localparam logic [2:0] PH_DATA   = 3'd4;

    localparam logic [1:0]        MAX_PENDING = 2'd2;
    localparam logic [RAM_AW-1:0] BANK1_BASE  = RAM_AW'(STORE_DEPTH);

    logic [2:0]       phase_reg, phase_next;
    logic [7:0]       toggle_reg, toggle_next;
    logic [7:0]       len_reg, len_next;
    logic [7:0]       chk_reg, chk_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sum_reg, sum_next;
    logic [7:0]       crc_reg, crc_next;
    logic             bank_reg, bank_next;
    logic [1:0]       pending_reg, pending_next;

    logic             accept;
    logic [7:0]       absorb_byte;
    logic [7:0]       sum_base;
    logic [7:0]       crc_base;
    logic [7:0]       sum_abs;
    logic [7:0]       crc_abs;
    logic             check_ok;
    logic [CNT_W-1:0] count_inc;
    logic             finish;

    // Stall while the queue is full, or while both RAM banks are still
    // waiting to be delivered and this word could claim a bank.
    assign in_ready = !queue_full &&
                      !((pending_reg == MAX_PENDING) &&
                        ((phase_reg == PH_LEN) || (phase_reg == PH_DATA)));
    assign accept = in_valid && in_ready;

    // Running sum and CRC; a start byte restarts both, the checksum byte
    // counts as zero.
    assign absorb_byte = (phase_reg == PH_CHK) ? 8'h00 : rx_byte;
    assign sum_base    = (phase_reg == PH_HUNT) ? 8'h00 : sum_reg;
    assign crc_base    = (phase_reg == PH_HUNT) ? 8'h00 : crc_reg;
    assign sum_abs     = sum_base + absorb_byte;
    assign crc_abs     = crc8_step(crc_base, absorb_byte);
    assign count_inc   = count_reg + CNT_W'(1);

    // Checksum verdict after the current byte has been absorbed.
    always_comb begin
        case (check_mode)
            CHECK_EITHER:   check_ok = (sum_abs == chk_reg) || (crc_abs == chk_reg);
            CHECK_SUM_ONLY: check_ok = (sum_abs == chk_reg);
            default:        check_ok = (crc_abs == chk_reg);
        endcase
    end

    // Parser state machine.
    always_comb begin
        phase_next  = phase_reg;
        toggle_next = toggle_reg;
        len_next    = len_reg;
        chk_next    = chk_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        crc_next    = crc_reg;
        bank_next   = bank_reg;
        push        = 1'b0;
        push_cmd    = '{deliver: 1'b0, kind: KIND_REJECT, cause: CAUSE_NONE,
                        len: 8'h00, bank: bank_reg};
        ram_we      = 1'b0;
        ram_waddr   = (bank_reg ? BANK1_BASE : '0) + RAM_AW'(count_reg);
        ram_wdata   = rx_byte;
        finish      = 1'b0;

        if (accept) begin
            case (phase_reg)
                PH_TOGGLE: begin
                    if (rx_byte == ACK_BYTE) begin
                        push          = 1'b1;
                        push_cmd.kind = KIND_ACK;
                        phase_next    = PH_HUNT;
                    end else if (!room_ok) begin
                        push           = 1'b1;
                        push_cmd.cause = CAUSE_FULL;
                        phase_next     = PH_HUNT;
                    end else if (rx_byte == toggle_reg) begin
                        push           = 1'b1;
                        push_cmd.cause = CAUSE_DUP;
                        phase_next     = PH_HUNT;
                    end else begin
                        sum_next   = sum_abs;
                        crc_next   = crc_abs;
                        phase_next = PH_CHK;
                    end
                end
                PH_CHK: begin
                    chk_next   = rx_byte;
                    sum_next   = sum_abs;
                    crc_next   = crc_abs;
                    phase_next = PH_LEN;
                end
                PH_LEN: begin
                    if ((rx_byte < MIN_LEN) || (rx_byte > MAX_LEN)) begin
                        push           = 1'b1;
                        push_cmd.cause = CAUSE_BAD;
                        phase_next     = PH_HUNT;
                    end else begin
                        len_next   = rx_byte;
                        sum_next   = sum_abs;
                        crc_next   = crc_abs;
                        count_next = '0;
                        phase_next = PH_DATA;
                        finish     = (rx_byte == MIN_LEN);
                    end
                end
                PH_DATA: begin
                    ram_we     = 1'b1;
                    sum_next   = sum_abs;
                    crc_next   = crc_abs;
                    count_next = count_inc;
                    finish     = (8'(count_inc) + MIN_LEN) >= len_reg;
                end
                default: begin
                    if (rx_byte == START_BYTE) begin
                        sum_next   = sum_abs;
                        crc_next   = crc_abs;
                        phase_next = PH_TOGGLE;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
            endcase

            // End of frame: deliver it from the current bank, or reject it.
            if (finish) begin
                push       = 1'b1;
                phase_next = PH_HUNT;
                if (check_ok) begin
                    push_cmd.deliver = 1'b1;
                    push_cmd.kind    = KIND_DATA;
                    push_cmd.len     = (phase_reg == PH_LEN) ? rx_byte : len_reg;
                    toggle_next      = (toggle_reg == 8'h00) ? 8'h01 : 8'h00;
                    bank_next        = !bank_reg;
                end else begin
                    push_cmd.cause = CAUSE_BAD;
                end
            end
        end
    end

    // Frames queued or under delivery, each holding one RAM bank.
    always_comb begin
        pending_next = pending_reg;
        if (push && push_cmd.deliver && !deliver_done) begin
            pending_next = pending_reg + 2'd1;
        end else if (!(push && push_cmd.deliver) && deliver_done) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HUNT;
            toggle_reg  <= 8'h00;
            len_reg     <= 8'h00;
            chk_reg     <= 8'h00;
            count_reg   <= '0;
            sum_reg     <= 8'h00;
            crc_reg     <= 8'h00;
            bank_reg    <= 1'b0;
            pending_reg <= 2'd0;
        end else begin
            phase_reg   <= phase_next;
            toggle_reg  <= toggle_next;
            len_reg     <= len_next;
            chk_reg     <= chk_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            crc_reg     <= crc_next;
            bank_reg    <= bank_next;
            pending_reg <= pending_next;
        end
    end

endmodule

`default_nettype wire

[rtl/fpr_cmd_fifo.sv]
// Two-entry command queue between the parser and the delivery side.
// Depends on fpr_pkg for the command type.
`default_nettype none

module fpr_cmd_fifo (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  fpr_pkg::cmd_t      push_cmd,
    input  wire logic          pop,
    output fpr_pkg::cmd_t      head_cmd,
    output logic               full,
    output logic               empty
);
    import fpr_pkg::*;

    localparam logic [1:0] DEPTH = 2'd2;

    cmd_t       entry_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] fill_reg, fill_next;

    assign full     = (fill_reg == DEPTH);
    assign empty    = (fill_reg == 2'd0);
    assign head_cmd = entry_reg[rptr_reg];

    // Pointer and fill update; pushes only arrive while not full.
    always_comb begin
        wptr_next = push ? !wptr_reg : wptr_reg;
        rptr_next = pop  ? !rptr_reg : rptr_reg;
        fill_next = fill_reg;
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            fill_reg <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            fill_reg <= fill_next;
        end
    end

endmodule

`default_nettype wire

[rtl/fpr_back.sv]
// Delivery side: takes commands from the queue, reads frame bytes from the
// RAM and drives the registered result channel. Depends on fpr_pkg.
`default_nettype none

module fpr_back (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       queue_empty,
    input  fpr_pkg::cmd_t                   head_cmd,
    output logic                            pop,
    output logic                            ram_re,
    output logic      [fpr_pkg::RAM_AW-1:0] ram_raddr,
    input  wire logic [7:0]                 ram_rdata,
    output logic                            deliver_done,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic      [1:0]                 out_kind,
    output logic      [7:0]                 out_byte,
    output logic                            out_send_ack,
    output logic      [1:0]                 out_cause,
    output logic                            out_last
);
    import fpr_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_RD   = 2'd1;
    localparam logic [1:0] B_LD   = 2'd2;

    localparam logic [RAM_AW-1:0] BANK1_BASE = RAM_AW'(STORE_DEPTH);

    logic [1:0]       state_reg, state_next;
    logic             valid_reg, valid_next;
    logic [1:0]       kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    logic             ack_reg, ack_next;
    logic [1:0]       cause_reg, cause_next;
    logic             last_reg, last_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] ndata_reg, ndata_next;
    logic             bank_reg, bank_next;

    logic             out_free;
    logic             len_fin;
    logic             data_fin;

    assign out_free = !valid_reg || out_ready;
    assign len_fin  = (head_cmd.len == MIN_LEN);
    assign data_fin = ((pos_reg + CNT_W'(1)) == ndata_reg);

    assign ram_raddr = (bank_reg ? BANK1_BASE : '0) + RAM_AW'(pos_reg);

    // Delivery sequencer: length byte first, then one RAM read per data word; acks and rejects are one word.
    always_comb begin
        state_next   = state_reg;
        valid_next   = valid_reg && !out_ready;
        kind_next    = kind_reg;
        byte_next    = byte_reg;
        ack_next     = ack_reg;
        cause_next   = cause_reg;
        last_next    = last_reg;
        pos_next     = pos_reg;
        ndata_next   = ndata_reg;
        bank_next    = bank_reg;
        pop          = 1'b0;
        ram_re       = 1'b0;
        deliver_done = 1'b0;

        case (state_reg)
            B_IDLE: begin
                if (!queue_empty && out_free) begin
                    pop        = 1'b1;
                    valid_next = 1'b1;
                    kind_next  = head_cmd.kind;
                    cause_next = head_cmd.cause;
                    if (head_cmd.deliver) begin
                        byte_next = head_cmd.len;
                        ack_next  = len_fin;
                        last_next = len_fin;
                        if (len_fin) begin
                            deliver_done = 1'b1;
                        end else begin
                            pos_next   = '0;
                            ndata_next = CNT_W'(head_cmd.len - MIN_LEN);
                            bank_next  = head_cmd.bank;
                            state_next = B_RD;
                        end
                    end else begin
                        byte_next = 8'h00;
                        ack_next  = 1'b0;
                        last_next = 1'b1;
                    end
                end
            end
            B_RD: begin
                // The output register is empty by the time the data arrives.
                if (out_free) begin
                    ram_re     = 1'b1;
                    state_next = B_LD;
                end
            end
            B_LD: begin
                valid_next = 1'b1;
                kind_next  = KIND_DATA;
                cause_next = CAUSE_NONE;
                byte_next  = ram_rdata;
                ack_next   = data_fin;
                last_next  = data_fin;
                if (data_fin) begin
                    deliver_done = 1'b1;
                    state_next   = B_IDLE;
                end else begin
                    pos_next   = pos_reg + CNT_W'(1);
                    state_next = B_RD;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        byte_reg  <= byte_next;
        ack_reg   <= ack_next;
        cause_reg <= cause_next;
        last_reg  <= last_next;
        pos_reg   <= pos_next;
        ndata_reg <= ndata_next;
        bank_reg  <= bank_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= B_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid    = valid_reg;
    assign out_kind     = kind_reg;
    assign out_byte     = byte_reg;
    assign out_send_ack = ack_reg;
    assign out_cause    = cause_reg;
    assign out_last     = last_reg;

endmodule

`default_nettype wire

[rtl/framed_packet_receiver_unit.sv]
// Top level of the framed packet receiver: configuration port, parser,
// command queue, frame RAM and delivery side. Depends on all fpr_* files.
//
//   channel   direction  handshake                  contents
//   s_axis    in         s_tvalid / s_tready        tdata: rx_byte, room_ok
//   m_axis    out        m_tvalid / m_tready        tdata: out_byte, send_ack,
//                                                   reject_cause; tuser: kind
//   apb       in         psel, penable, pwrite      check_mode at address 0
//
// The parser takes one word per cycle while not stalled. Each data word of a
// delivered frame is read from the frame RAM, then loaded into the output.
// Reset is synchronous and active low; the RAM needs no clearing pass.
// The parser stalls only when the two-entry command queue is full, or when
// both RAM banks still await delivery and the word is a length or data byte.
`default_nettype none

module framed_packet_receiver_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [7:0] rx_byte, [8] room_ok, [15:9] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [15:0] m_tdata,   // [7:0] out_byte, [8] send_ack,
                                        // [10:9] reject_cause, [15:11] zero
    output logic      [1:0]  m_tuser,   // [1:0] kind
    output logic             m_tlast,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);
    import fpr_pkg::*;

    localparam logic REG_CHECK_MODE = 1'b0;

    logic [1:0]        check_mode_reg, check_mode_next;
    logic              cfg_write;

    logic              push;
    cmd_t              push_cmd;
    cmd_t              head_cmd;
    logic              queue_full;
    logic              queue_empty;
    logic              pop;
    logic              deliver_done;
    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [RAM_AW-1:0] ram_raddr;
    logic [7:0]        ram_rdata;
    logic [7:0]        res_byte;
    logic              res_ack;
    logic [1:0]        res_cause;

    // Configuration register
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign check_mode_next = (cfg_write && (paddr[2] == REG_CHECK_MODE)) ?
                             pwdata[1:0] : check_mode_reg;
    assign prdata = (paddr[2] == REG_CHECK_MODE) ? {30'd0, check_mode_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            check_mode_reg <= CHECK_EITHER;
        end else begin
            check_mode_reg <= check_mode_next;
        end
    end

    fpr_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .rx_byte      (s_tdata[7:0]),
        .room_ok      (s_tdata[8]),
        .check_mode   (check_mode_reg),
        .push         (push),
        .push_cmd     (push_cmd),
        .queue_full   (queue_full),
        .deliver_done (deliver_done),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata)
    );

    fpr_cmd_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .full     (queue_full),
        .empty    (queue_empty)
    );

    fpr_ram #(
        .WIDTH (8),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    fpr_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .queue_empty  (queue_empty),
        .head_cmd     (head_cmd),
        .pop          (pop),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .deliver_done (deliver_done),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_kind     (m_tuser),
        .out_byte     (res_byte),
        .out_send_ack (res_ack),
        .out_cause    (res_cause),
        .out_last     (m_tlast)
    );

    assign m_tdata = {5'd0, res_cause, res_ack, res_byte};

endmodule

`default_nettype wire
